### rtl/core/gmds_pkg.sv
package gmds_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int DEPTH_W  = ADDR_W + 1;
  localparam int MARK_W   = 3;
  localparam int DIR_W    = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [MARK_W-1:0] MARK_OPEN  = 3'd0;
  localparam logic [MARK_W-1:0] MARK_WALL  = 3'd1;
  localparam logic [MARK_W-1:0] MARK_END   = 3'd2;
  localparam logic [MARK_W-1:0] MARK_BACK  = 3'd3;
  localparam logic [MARK_W-1:0] MARK_TRACE = 3'd4;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       cell_kind;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [MARK_W-1:0] cell_mark;
  } out_item_t;

endpackage

### rtl/core/gmds_ram.sv
module gmds_ram #(
  parameter int DATA_W = 3,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/grid_maze_dfs_solver.sv
// Cell write: no result; a new transaction may follow in the next cycle.
// Cell read: result strobed after the mark memory read and the result register (only the latter outside the grid).
// Solve: a neighbour probed passes ST_PROBE and ST_CHECK, a backtrack step ST_PROBE and ST_POP,
//   as the cell mark and stack memories are read registered; busy stays high throughout.
// Reset clears control state, the stack depth and sets both grid sizes to 64;
//   cell marks stay undefined until written. Results cannot be stalled.
module grid_maze_dfs_solver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  gmds_pkg::in_item_t                  in_item,
  output logic                                busy,
  output logic                                out_strobe,
  output gmds_pkg::out_item_t                 out_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmds_pkg::CFG_W-1:0]          cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RDWAIT = 6'b000010,
    ST_START  = 6'b000100,
    ST_PROBE  = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_POP    = 6'b100000
  } state_t;

  localparam logic [gmds_pkg::CFG_W-1:0] ROWS_MAX = gmds_pkg::CFG_W'(gmds_pkg::MAX_ROWS);
  localparam logic [gmds_pkg::CFG_W-1:0] COLS_MAX = gmds_pkg::CFG_W'(gmds_pkg::MAX_COLS);
  localparam logic [gmds_pkg::DEPTH_W-1:0] STACK_FULL =
    gmds_pkg::DEPTH_W'(gmds_pkg::CELLS);

  state_t state_r, state_nxt;
  logic [gmds_pkg::ROW_W-1:0]   cur_row_r, cur_row_nxt, nbr_row_r, nbr_row_nxt;
  logic [gmds_pkg::COL_W-1:0]   cur_col_r, cur_col_nxt, nbr_col_r, nbr_col_nxt;
  logic [2:0]                   next_r, next_nxt;
  logic [gmds_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [gmds_pkg::CFG_W-1:0]   grid_rows_r, grid_cols_r;
  logic                         out_strobe_r, out_strobe_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [gmds_pkg::MARK_W-1:0]  out_mark_r, out_mark_nxt;

  logic [gmds_pkg::CFG_W-1:0]   rows_lim, cols_lim;
  logic                         in_inside;
  logic                         nbr_ok;
  logic [gmds_pkg::ROW_W-1:0]   nbr_row;
  logic [gmds_pkg::COL_W-1:0]   nbr_col;
  logic [gmds_pkg::DEPTH_W-1:0] depth_m1;

  logic                         cell_we, cell_re;
  logic [gmds_pkg::ADDR_W-1:0]  cell_waddr, cell_raddr;
  logic [gmds_pkg::MARK_W-1:0]  cell_wdata, cell_rdata;
  logic                         stk_we, stk_re;
  logic [gmds_pkg::ADDR_W-1:0]  stk_waddr, stk_raddr;
  logic [gmds_pkg::DIR_W-1:0]   stk_wdata, stk_rdata;

  gmds_ram #(
    .DATA_W (gmds_pkg::MARK_W),
    .ADDR_W (gmds_pkg::ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gmds_ram #(
    .DATA_W (gmds_pkg::DIR_W),
    .ADDR_W (gmds_pkg::ADDR_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_result.found     = out_found_r;
  assign out_result.cell_mark = out_mark_r;

  assign rows_lim  = (grid_rows_r > ROWS_MAX) ? ROWS_MAX : grid_rows_r;
  assign cols_lim  = (grid_cols_r > COLS_MAX) ? COLS_MAX : grid_cols_r;
  assign in_inside = ({1'b0, in_item.row} < rows_lim) && ({1'b0, in_item.col} < cols_lim);
  assign depth_m1  = depth_r - gmds_pkg::DEPTH_W'(1);

  always_comb begin
    nbr_row = cur_row_r;
    nbr_col = cur_col_r;
    nbr_ok  = 1'b0;
    case (next_r[1:0])
      gmds_pkg::DIR_UP: begin
        nbr_row = cur_row_r - gmds_pkg::ROW_W'(1);
        nbr_ok  = (cur_row_r != '0);
      end
      gmds_pkg::DIR_LEFT: begin
        nbr_col = cur_col_r - gmds_pkg::COL_W'(1);
        nbr_ok  = (cur_col_r != '0);
      end
      gmds_pkg::DIR_RIGHT: begin
        nbr_col = cur_col_r + gmds_pkg::COL_W'(1);
        nbr_ok  = (({1'b0, cur_col_r} + gmds_pkg::CFG_W'(1)) < cols_lim);
      end
      gmds_pkg::DIR_DOWN: begin
        nbr_row = cur_row_r + gmds_pkg::ROW_W'(1);
        nbr_ok  = (({1'b0, cur_row_r} + gmds_pkg::CFG_W'(1)) < rows_lim);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    nbr_row_nxt    = nbr_row_r;
    nbr_col_nxt    = nbr_col_r;
    next_nxt       = next_r;
    depth_nxt      = depth_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = out_found_r;
    out_mark_nxt   = out_mark_r;
    cell_we        = 1'b0;
    cell_waddr     = {cur_row_r, cur_col_r};
    cell_wdata     = gmds_pkg::MARK_TRACE;
    cell_re        = 1'b0;
    cell_raddr     = {in_item.row, in_item.col};
    stk_we         = 1'b0;
    stk_waddr      = depth_r[gmds_pkg::ADDR_W-1:0];
    stk_wdata      = next_r[1:0];
    stk_re         = 1'b0;
    stk_raddr      = depth_m1[gmds_pkg::ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cur_row_nxt = in_item.row;
          cur_col_nxt = in_item.col;
          case (in_item.opcode)
            gmds_pkg::OP_WRITE: begin
              cell_we    = in_inside;
              cell_waddr = {in_item.row, in_item.col};
              cell_wdata = (in_item.cell_kind == gmds_pkg::KIND_UNUSED) ?
                           gmds_pkg::MARK_OPEN : {1'b0, in_item.cell_kind};
            end
            gmds_pkg::OP_SOLVE: begin
              depth_nxt = '0;
              if (in_inside) begin
                cell_re   = 1'b1;
                state_nxt = ST_START;
              end else begin
                out_strobe_nxt = 1'b1;
                out_found_nxt  = 1'b0;
                out_mark_nxt   = gmds_pkg::MARK_OPEN;
              end
            end
            gmds_pkg::OP_READ: begin
              if (in_inside) begin
                cell_re   = 1'b1;
                state_nxt = ST_RDWAIT;
              end else begin
                out_strobe_nxt = 1'b1;
                out_found_nxt  = 1'b0;
                out_mark_nxt   = gmds_pkg::MARK_WALL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_strobe_nxt = 1'b1;
        out_found_nxt  = 1'b0;
        out_mark_nxt   = cell_rdata;
        state_nxt      = ST_IDLE;
      end
      ST_START: begin
        out_mark_nxt = gmds_pkg::MARK_OPEN;
        if (cell_rdata == gmds_pkg::MARK_END) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (cell_rdata != gmds_pkg::MARK_OPEN) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          cell_we   = 1'b1;
          next_nxt  = '0;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        out_mark_nxt = gmds_pkg::MARK_OPEN;
        if (next_r[2]) begin
          cell_we    = 1'b1;
          cell_wdata = gmds_pkg::MARK_BACK;
          if (depth_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_found_nxt  = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            depth_nxt = depth_m1;
            stk_re    = 1'b1;
            state_nxt = ST_POP;
          end
        end else if (nbr_ok) begin
          cell_re     = 1'b1;
          cell_raddr  = {nbr_row, nbr_col};
          nbr_row_nxt = nbr_row;
          nbr_col_nxt = nbr_col;
          state_nxt   = ST_CHECK;
        end else begin
          next_nxt = next_r + 3'd1;
        end
      end
      ST_CHECK: begin
        out_mark_nxt = gmds_pkg::MARK_OPEN;
        if (cell_rdata == gmds_pkg::MARK_END) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else if ((cell_rdata == gmds_pkg::MARK_OPEN) && (depth_r != STACK_FULL)) begin
          cell_we     = 1'b1;
          cell_waddr  = {nbr_row_r, nbr_col_r};
          stk_we      = 1'b1;
          depth_nxt   = depth_r + gmds_pkg::DEPTH_W'(1);
          cur_row_nxt = nbr_row_r;
          cur_col_nxt = nbr_col_r;
          next_nxt    = '0;
          state_nxt   = ST_PROBE;
        end else begin
          next_nxt  = next_r + 3'd1;
          state_nxt = ST_PROBE;
        end
      end
      ST_POP: begin
        case (stk_rdata)
          gmds_pkg::DIR_UP:    cur_row_nxt = cur_row_r + gmds_pkg::ROW_W'(1);
          gmds_pkg::DIR_LEFT:  cur_col_nxt = cur_col_r + gmds_pkg::COL_W'(1);
          gmds_pkg::DIR_RIGHT: cur_col_nxt = cur_col_r - gmds_pkg::COL_W'(1);
          gmds_pkg::DIR_DOWN:  cur_row_nxt = cur_row_r - gmds_pkg::ROW_W'(1);
          default: begin
          end
        endcase
        next_nxt  = {1'b0, stk_rdata} + 3'd1;
        state_nxt = ST_PROBE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      depth_r      <= '0;
      out_strobe_r <= 1'b0;
      grid_rows_r  <= ROWS_MAX;
      grid_cols_r  <= COLS_MAX;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmds_pkg::CFG_ROWS) begin
          grid_rows_r <= cfg_data;
        end
        if (cfg_index == gmds_pkg::CFG_COLS) begin
          grid_cols_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    nbr_row_r   <= nbr_row_nxt;
    nbr_col_r   <= nbr_col_nxt;
    next_r      <= next_nxt;
    out_found_r <= out_found_nxt;
    out_mark_r  <= out_mark_nxt;
  end

  a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> $past(state_r == ST_PROBE))
    else $error("neighbour check without a probe");

  a_pop_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> $past(state_r == ST_PROBE) && $past(depth_r != '0))
    else $error("stack pop on an empty stack");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= STACK_FULL)
    else $error("stack depth beyond capacity");

  a_rdwait_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDWAIT) |=> out_strobe)
    else $error("read transaction gave no result");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !start) |-> !cell_we && !stk_we)
    else $error("memory write while idle");

endmodule
